>>> src/circular_deque_defines.svh
// Assertion macros for the circular deque RTL.
// Included by the top level; no dependencies.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef SYNTHESIS

`define CDQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CDQ_ASSERT_SAME(label, clk, rst, ante, cons, msg)

`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> src/cdq_pkg.sv
// Shared types and constants for the circular deque.
// No dependencies; imported by every module of the block.
package cdq_pkg;

   localparam int DATA_W   = 32;
   localparam int ACTION_W = 3;
   localparam int CFG_W    = 11;

   localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd4;

   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic                     succeeded;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic load;
      logic cfg_write;
   } cmd_type;

endpackage

>>> src/cdq_datapath.sv
// Datapath of the circular deque: entry store, head, count, capacity and result register.
// Depends on cdq_pkg.
module cdq_datapath import cdq_pkg::*; #(
   parameter int MAX_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  req_type           req_data,
   input  logic [CFG_W-1:0]  csr_data,
   output rsp_type           rsp_data
);

   localparam int ADDR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int COUNT_W = $clog2(MAX_DEPTH + 1);
   localparam int SUM_W   = ((COUNT_W > ADDR_W) ? COUNT_W : ADDR_W) + 1;
   localparam int CAP_W   = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DEPTH - 1);
   localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(MAX_DEPTH);
   localparam logic [CAP_W-1:0]  DEPTH_CAP = CAP_W'(MAX_DEPTH);

   logic signed [DATA_W-1:0] entry_store_mem [MAX_DEPTH];

   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CFG_W-1:0]   cap_ff;

   logic signed [DATA_W-1:0] rd_front_ff, rd_rear_ff, wr_data_ff;
   logic ok_ff, empty_ff, full_ff, hit_front_ff, hit_rear_ff;
   rsp_type rsp_ff;

   logic [CAP_W-1:0]  cap_ext, eff_cap;
   logic              full, empty, ok, wr_en;
   logic [ADDR_W-1:0] wr_addr, head_dec, head_inc, tail_addr, rear_addr;
   logic [SUM_W-1:0]  tail_sum, rear_sum;

   // Capacity is clamped to 1..MAX_DEPTH.
   always_comb begin
      cap_ext = CAP_W'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = CAP_W'(1);
      end else if (cap_ext > DEPTH_CAP) begin
         eff_cap = DEPTH_CAP;
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full     = CAP_W'(count_ff) >= eff_cap;
   assign empty    = count_ff == '0;
   assign head_dec = (head_ff == '0) ? LAST_ADDR : head_ff - ADDR_W'(1);
   assign head_inc = (head_ff == LAST_ADDR) ? '0 : head_ff + ADDR_W'(1);

   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= DEPTH_SUM) begin
         tail_sum = tail_sum - DEPTH_SUM;
      end
      tail_addr = tail_sum[ADDR_W-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      ok       = 1'b1;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      case (req_data.action)
         ACT_PUSH_FRONT: begin
            if (full) begin
               ok = 1'b0;
            end else begin
               head_in  = head_dec;
               wr_addr  = head_dec;
               wr_en    = 1'b1;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ACT_PUSH_BACK: begin
            if (full) begin
               ok = 1'b0;
            end else begin
               wr_addr  = tail_addr;
               wr_en    = 1'b1;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (empty) begin
               ok = 1'b0;
            end else begin
               head_in  = head_inc;
               count_in = count_ff - COUNT_W'(1);
            end
         end
         ACT_POP_BACK: begin
            if (empty) begin
               ok = 1'b0;
            end else begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // The rear address is only meaningful when the deque is not empty afterwards.
   always_comb begin
      rear_sum = SUM_W'(head_in) + SUM_W'(count_in) - SUM_W'(1);
      if (rear_sum >= DEPTH_SUM) begin
         rear_sum = rear_sum - DEPTH_SUM;
      end
      rear_addr = rear_sum[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         if (cmd.start) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         if (cmd.cfg_write) begin
            cap_ff <= csr_data;
         end
      end
   end

   // The store returns old data on a same-address write, so the new entry is
   // forwarded from a register when the read hits the written slot.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         if (wr_en) begin
            entry_store_mem[wr_addr] <= req_data.data_value;
         end
         rd_front_ff  <= entry_store_mem[head_in];
         rd_rear_ff   <= entry_store_mem[rear_addr];
         wr_data_ff   <= req_data.data_value;
         hit_front_ff <= wr_en && (wr_addr == head_in);
         hit_rear_ff  <= wr_en && (wr_addr == rear_addr);
         ok_ff        <= ok;
         empty_ff     <= count_in == '0;
         full_ff      <= CAP_W'(count_in) >= eff_cap;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.succeeded <= ok_ff;
         rsp_ff.is_empty  <= empty_ff;
         rsp_ff.is_full   <= full_ff;
         if (empty_ff) begin
            rsp_ff.front_value <= EMPTY_VALUE;
            rsp_ff.rear_value  <= EMPTY_VALUE;
         end else begin
            rsp_ff.front_value <= hit_front_ff ? wr_data_ff : rd_front_ff;
            rsp_ff.rear_value  <= hit_rear_ff ? wr_data_ff : rd_rear_ff;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> src/cdq_ctrl.sv
// Controller of the circular deque: handshakes and sequencing of the datapath.
// Depends on cdq_pkg.
module cdq_ctrl import cdq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  logic    csr_valid,
   output logic    csr_ready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOAD = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // The result register may be refilled once its current transfer completes.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd.start     = 1'b0;
      cmd.load      = 1'b0;
      cmd.cfg_write = csr_valid;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (slot_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

endmodule

>>> src/circular_deque.sv
// Circular deque of signed 32-bit entries in a ring of MAX_DEPTH slots, with a
// configurable capacity, built from cdq_ctrl and cdq_datapath over cdq_pkg.
// Each request pushes or pops at either end, or only queries, and gives one
// response with success, the front and rear entries (-1 when empty) and the
// empty and full flags. On a request the pointers are updated, the store is
// written and the new front and rear are read through the store's registered
// read ports; the response is loaded once the result register is free. The next
// request is accepted only after that load; a waiting response does not block its
// acceptance, only its loading. Capacity writes are taken at any time.
`include "circular_deque_defines.svh"

module circular_deque import cdq_pkg::*; #(
   parameter int MAX_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   cdq_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

   `CDQ_ASSERT_NEXT(a_start_then_busy, clock, reset, req_valid && req_ready, !req_ready, "request accepted while previous one still in flight")
   `CDQ_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.load, !rsp_valid || rsp_ready, "pending response overwritten")
   `CDQ_ASSERT_SAME(a_flags_exclusive, clock, reset, rsp_valid, !(rsp_data.is_empty && rsp_data.is_full), "response is both empty and full")
   `CDQ_ASSERT_SAME(a_refusal_cause, clock, reset, rsp_valid && !rsp_data.succeeded, rsp_data.is_full || rsp_data.is_empty, "refused action without full or empty deque")

endmodule
